### rtl/stsum_pkg.sv
// ----------------------------------------------------------------------------
// stsum_pkg
// shared constants for the segment tree range sum core
// ----------------------------------------------------------------------------
`default_nettype none
package stsum_pkg;
    localparam int LEVELS_DEF = 11;   // tree levels, root to leaves
    localparam int WORD_W     = 64;   // node and sum width
    localparam int IDX_W      = 10;   // leaf index field width
    localparam logic OP_SET   = 1'b0; // set one leaf
    localparam logic OP_QUERY = 1'b1; // range sum query
endpackage
`default_nettype wire

### rtl/stsum_cell.sv
// ----------------------------------------------------------------------------
// stsum_cell
// one tree level: node store, read-modify-write on update, sibling adds on query
// ----------------------------------------------------------------------------
`default_nettype none
module stsum_cell #(
    parameter int LEVELS = stsum_pkg::LEVELS_DEF,
    parameter int LVL    = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    output logic                             clear_done,
    input  wire logic                        in_valid,
    input  wire logic                        in_op,
    input  wire logic [LEVELS-1:0]           in_l,
    input  wire logic [LEVELS-1:0]           in_r,
    input  wire logic [stsum_pkg::WORD_W-1:0] in_value,
    input  wire logic [stsum_pkg::WORD_W-1:0] in_delta,
    input  wire logic [stsum_pkg::WORD_W-1:0] in_acc,
    output logic                             out_valid,
    output logic                             out_op,
    output logic [LEVELS-1:0]                out_l,
    output logic [LEVELS-1:0]                out_r,
    output logic [stsum_pkg::WORD_W-1:0]     out_value,
    output logic [stsum_pkg::WORD_W-1:0]     out_delta,
    output logic [stsum_pkg::WORD_W-1:0]     out_acc
);
    import stsum_pkg::*;

    localparam int  ADDR_W  = (LVL == 0) ? 1 : LVL;
    localparam int  DEPTH   = 1 << ADDR_W;
    localparam bit  IS_LEAF = (LVL == LEVELS - 1);

    logic [WORD_W-1:0] mem [DEPTH];

    logic [ADDR_W:0]    clr_cnt_reg;
    logic               busy_reg;
    logic               ends_reg;     // leaf query: end leaves still to add
    logic               op_reg;
    logic [LEVELS-1:0]  l_reg, r_reg;
    logic [WORD_W-1:0]  value_reg, delta_reg, acc_reg;
    logic [WORD_W-1:0]  rd_a_reg, rd_b_reg;

    logic               start_ends;
    logic [ADDR_W-1:0]  rd_a_addr, rd_b_addr, wr_addr;
    logic [WORD_W-1:0]  wr_data, add_a, add_b, delta_next;
    logic               gap;

    assign clear_done = clr_cnt_reg[ADDR_W];
    assign start_ends = IS_LEAF && (in_op == OP_QUERY);

    // read address select
    always_comb
    begin
        if (busy_reg)
        begin
            rd_a_addr = l_reg[ADDR_W-1:0] ^ ADDR_W'(1);
            rd_b_addr = r_reg[ADDR_W-1:0] ^ ADDR_W'(1);
        end
        else if (start_ends || in_op == OP_SET)
        begin
            rd_a_addr = in_l[ADDR_W-1:0];
            rd_b_addr = in_r[ADDR_W-1:0];
        end
        else
        begin
            rd_a_addr = in_l[ADDR_W-1:0] ^ ADDR_W'(1);
            rd_b_addr = in_r[ADDR_W-1:0] ^ ADDR_W'(1);
        end
    end

    always_comb
    begin
        gap   = ({1'b0, r_reg}) > ({1'b0, l_reg} + (LEVELS+1)'(1));
        add_a = '0;
        add_b = '0;
        if (ends_reg)
        begin
            if (l_reg <= r_reg) add_a = rd_a_reg;
            if (r_reg > l_reg)  add_b = rd_b_reg;
        end
        else if (gap)
        begin
            if (!l_reg[0]) add_a = rd_a_reg;
            if (r_reg[0])  add_b = rd_b_reg;
        end
        delta_next = IS_LEAF ? (value_reg - rd_a_reg) : delta_reg;
        wr_addr    = clear_done ? l_reg[ADDR_W-1:0] : clr_cnt_reg[ADDR_W-1:0];
        wr_data    = clear_done ? (rd_a_reg + delta_next) : '0;
    end

    // node store
    always_ff @(posedge clk)
    begin
        if (!clear_done || (busy_reg && !ends_reg && op_reg == OP_SET))
            mem[wr_addr] <= wr_data;
        if ((in_valid && !busy_reg) || (busy_reg && ends_reg))
        begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            ends_reg    <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            out_valid <= 1'b0;
            if (!clear_done)
                clr_cnt_reg <= clr_cnt_reg + (ADDR_W+1)'(1);
            if (!busy_reg)
            begin
                if (in_valid)
                begin
                    busy_reg <= 1'b1;
                    ends_reg <= start_ends;
                end
            end
            else if (ends_reg)
                ends_reg <= 1'b0;
            else
            begin
                busy_reg  <= 1'b0;
                out_valid <= 1'b1;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (!busy_reg && in_valid)
        begin
            op_reg    <= in_op;
            l_reg     <= in_l;
            r_reg     <= in_r;
            value_reg <= in_value;
            delta_reg <= in_delta;
            acc_reg   <= in_acc;
        end
        else if (busy_reg && op_reg == OP_QUERY)
            acc_reg <= acc_reg + add_a + add_b;
        if (busy_reg && !ends_reg)
        begin
            out_op    <= op_reg;
            out_l     <= l_reg >> 1;
            out_r     <= r_reg >> 1;
            out_value <= value_reg;
            out_delta <= delta_next;
            out_acc   <= acc_reg + add_a + add_b;
        end
    end
endmodule
`default_nettype wire

### rtl/segment_tree_range_sum_update_core.sv
// ----------------------------------------------------------------------------
// segment_tree_range_sum_update_core
// segment tree with point set and inclusive range sum, one cell per level
// ----------------------------------------------------------------------------
// Each input word is either a leaf set or a range sum query, selected by tuser.
// Each gives exactly one output word: the sum, or zero for a set. The tree is a
// row of cells, one per level, leaf level first. An item walks the row from the
// leaf cell to the root cell, each cell doing a registered read, then an add and
// write back. The leaf cell takes its word straight from the input; for a query
// it first reads and adds the two end leaves. Only one item is in flight at a
// time, so a new word is taken only once the last result is in the output
// register. After reset every cell sweeps its node store to zero one entry a
// cycle; the leaf cell is longest, so no word is taken until its sweep is done.
// A finished result waits in the output register while the next word is
// accepted.
`default_nettype none
module segment_tree_range_sum_update_core #(
    parameter int LEVELS = stsum_pkg::LEVELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // position[9:0], value[73:10], left_leaf[83:74], right_leaf[93:84]
    input  wire logic [95:0] s_axis_tdata,
    // operation[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sum[63:0]
    output logic [63:0]      m_axis_tdata
);
    import stsum_pkg::*;

    // chain links: index k is the input of the cell at level k-1... stage LEVELS feeds the leaves
    logic              ch_valid [LEVELS+1];
    logic              ch_op    [LEVELS+1];
    logic [LEVELS-1:0] ch_l     [LEVELS+1];
    logic [LEVELS-1:0] ch_r     [LEVELS+1];
    logic [WORD_W-1:0] ch_value [LEVELS+1];
    logic [WORD_W-1:0] ch_delta [LEVELS+1];
    logic [WORD_W-1:0] ch_acc   [LEVELS+1];
    logic [LEVELS-1:0] cell_done;

    logic              busy_reg;
    logic              pend_reg;       // root result waiting for the output register
    logic [WORD_W-1:0] pend_sum_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_sum_reg;

    logic              in_op;
    logic [IDX_W-1:0]  in_pos, in_left, in_right;
    logic [WORD_W-1:0] in_value;
    logic              accept;
    logic [WORD_W-1:0] done_sum;
    logic              out_free;

    assign in_op    = s_axis_tuser;
    assign in_pos   = s_axis_tdata[9:0];
    assign in_value = s_axis_tdata[73:10];
    assign in_left  = s_axis_tdata[83:74];
    assign in_right = s_axis_tdata[93:84];

    assign s_axis_tready = !busy_reg && (&cell_done);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // launch into the leaf cell, leaf index mapped to its heap node
    assign ch_valid[LEVELS] = accept;
    assign ch_op[LEVELS]    = in_op;
    assign ch_l[LEVELS]     = {1'b1, (LEVELS-1)'((in_op == OP_SET) ? in_pos : in_left)};
    assign ch_r[LEVELS]     = {1'b1, (LEVELS-1)'((in_op == OP_SET) ? in_pos : in_right)};
    assign ch_value[LEVELS] = in_value;
    assign ch_delta[LEVELS] = '0;
    assign ch_acc[LEVELS]   = '0;

    genvar k;
    generate
        for (k = 0; k < LEVELS; k++)
        begin : g_level
            stsum_cell #(.LEVELS(LEVELS), .LVL(k)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .clear_done (cell_done[k]),
                .in_valid   (ch_valid[k+1]),
                .in_op      (ch_op[k+1]),
                .in_l       (ch_l[k+1]),
                .in_r       (ch_r[k+1]),
                .in_value   (ch_value[k+1]),
                .in_delta   (ch_delta[k+1]),
                .in_acc     (ch_acc[k+1]),
                .out_valid  (ch_valid[k]),
                .out_op     (ch_op[k]),
                .out_l      (ch_l[k]),
                .out_r      (ch_r[k]),
                .out_value  (ch_value[k]),
                .out_delta  (ch_delta[k]),
                .out_acc    (ch_acc[k])
            );
        end
    endgenerate

    // a set reports zero
    assign done_sum      = (ch_op[0] == OP_QUERY) ? ch_acc[0] : '0;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                busy_reg <= 1'b1;
            if (out_free)
            begin
                if (pend_reg)
                begin
                    out_valid_reg <= 1'b1;
                    pend_reg      <= 1'b0;
                    busy_reg      <= 1'b0;
                end
                else if (ch_valid[0])
                begin
                    out_valid_reg <= 1'b1;
                    busy_reg      <= 1'b0;
                end
                else
                    out_valid_reg <= 1'b0;
            end
            else if (ch_valid[0])
                pend_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_free && ch_valid[0])
            pend_sum_reg <= done_sum;
        if (out_free && pend_reg)
            out_sum_reg <= pend_sum_reg;
        else if (out_free && ch_valid[0])
            out_sum_reg <= done_sum;
    end

    // a parked result means the output register is still full
    a_pend_full: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg)
        else $error("result parked while output register empty");

    // no new word while an item is in the chain
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("word accepted while item in flight");

    // root result only arrives for an item in flight
    a_root_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ch_valid[0] |-> busy_reg && !pend_reg)
        else $error("unexpected root result");
endmodule
`default_nettype wire
